[sv/srr_pkg.sv]
// Shared types, codes and a helper function of the selective-repeat receiver.
package srr_pkg;

   localparam int unsigned SEQ_W     = 16;
   localparam int unsigned SLOT_BITS = 8;
   localparam int unsigned SLOTS     = 256;
   localparam int unsigned LEN_W     = 14;

   // result status codes
   localparam logic [2:0] RS_ACCEPTED  = 3'd0;
   localparam logic [2:0] RS_DUPLICATE = 3'd1;
   localparam logic [2:0] RS_OUTSIDE   = 3'd2;
   localparam logic [2:0] RS_NO_SEQ    = 3'd3;
   localparam logic [2:0] RS_RESET     = 3'd4;
   localparam logic [2:0] RS_READ_DONE = 3'd5;

   localparam logic CMD_SEGMENT = 1'b0;
   localparam logic CMD_READ    = 1'b1;

   typedef struct packed {
      logic             cmd;
      logic [15:0]      seq;
      logic             has_seq;
      logic             syn_flag;
      logic             rst_flag;
      logic [7:0]       payload_quads;
      logic [1:0]       pad_count;
      logic [LEN_W-1:0] read_len;
   } req_item_type;

   typedef struct packed {
      logic [2:0]       status;
      logic             ack_valid;
      logic [15:0]      ack_num;
      logic [7:0]       window_adv;
      logic [7:0]       delivered_count;
      logic [15:0]      next_expected;
      logic [LEN_W-1:0] fill_level;
      logic [LEN_W-1:0] read_count;
      logic             end_of_stream;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] seq;
      logic [7:0]  quads;
      logic [1:0]  pad;
   } entry_type;

   typedef enum logic [2:0] {
      CLS_READ, CLS_NO_SEQ, CLS_RESET, CLS_OUTSIDE, CLS_BEHIND, CLS_INSERT
   } cls_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_LOAD, OP_SIMPLE, OP_LOOKUP, OP_INSERT, OP_WREAD, OP_WSTEP, OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLASSIFY, ST_INSERT, ST_WREAD, ST_WCHK, ST_FINISH
   } state_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    out_free;
      logic    walk_ok;
   } dp_status_type;

   // advertised window: N minus held, saturating at zero
   function automatic logic [7:0] sat_adv(input logic [7:0] n, input logic [8:0] held);
      logic [8:0] n9;
      n9 = {1'b0, n};
      return (n9 > held) ? 8'(n9 - held) : 8'd0;
   endfunction

endpackage

[sv/srr_req_if.sv]
// Input channel of the receiver: valid/ready handshake with the request fields.
interface srr_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] seq;
   logic        has_seq;
   logic        syn_flag;
   logic        rst_flag;
   logic [7:0]  payload_quads;
   logic [1:0]  pad_count;
   logic [13:0] read_len;

   modport source (output valid, cmd, seq, has_seq, syn_flag, rst_flag, payload_quads,
                   pad_count, read_len, input ready);
   modport sink   (input valid, cmd, seq, has_seq, syn_flag, rst_flag, payload_quads,
                   pad_count, read_len, output ready);
endinterface

[sv/srr_rsp_if.sv]
// Result channel of the receiver: valid/ready handshake with the result fields.
interface srr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        ack_valid;
   logic [15:0] ack_num;
   logic [7:0]  window_adv;
   logic [7:0]  delivered_count;
   logic [15:0] next_expected;
   logic [13:0] fill_level;
   logic [13:0] read_count;
   logic        end_of_stream;

   modport source (output valid, status, ack_valid, ack_num, window_adv, delivered_count,
                   next_expected, fill_level, read_count, end_of_stream, input ready);
   modport sink   (input valid, status, ack_valid, ack_num, window_adv, delivered_count,
                   next_expected, fill_level, read_count, end_of_stream, output ready);
endinterface

[sv/srr_ctrl.sv]
// Controller state machine of the receiver: sequences lookup, insert and delivery walk.
module srr_ctrl
   import srr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      dp_cmd.op  = OP_NONE;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.op = OP_LOAD;
               state_in  = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (dp_status.cls == CLS_INSERT) begin
               dp_cmd.op = OP_LOOKUP;
               state_in  = ST_INSERT;
            end else if (dp_status.out_free) begin
               dp_cmd.op = OP_SIMPLE;
               state_in  = ST_IDLE;
            end
         end
         ST_INSERT: begin
            dp_cmd.op = OP_INSERT;
            state_in  = ST_WREAD;
         end
         ST_WREAD: begin
            dp_cmd.op = OP_WREAD;
            state_in  = ST_WCHK;
         end
         ST_WCHK: begin
            if (dp_status.walk_ok) begin
               dp_cmd.op = OP_WSTEP;
               state_in  = ST_WREAD;
            end else begin
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (dp_status.out_free) begin
               dp_cmd.op = OP_FINISH;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/srr_dp.sv]
// Datapath of the receiver: protocol state, reorder store, valid bits and result register.
module srr_dp
   import srr_pkg::*;
#(
   parameter int unsigned MAX_WINDOW = 255,
   parameter int unsigned BUF_BYTES  = 8192
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [7:0]    csr_wdata,
   input  req_item_type  req_item,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_item_type  rsp_item,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status
);

   localparam int unsigned FW = $clog2(BUF_BYTES + 1);
   localparam int unsigned SW = FW + 1;

   req_item_type        item_ff;
   logic [7:0]          win_ff;
   logic [7:0]          adv_ff;
   logic [8:0]          held_ff;
   logic [15:0]         base_ff;
   logic [FW-1:0]       fill_ff;
   logic                eof_ff;
   logic                dup_ff;
   logic [7:0]          count_ff;
   logic [SLOTS-1:0]    slot_valid_ff;
   entry_type           rdata_ff;
   logic                rsp_valid_ff;
   rsp_item_type        rsp_ff;

   entry_type           store_mem [SLOTS];

   logic [7:0]          n_eff;
   logic [7:0]          n_csr;
   logic [15:0]         base_eff;
   logic [15:0]         off;
   cls_type             cls;
   logic                hit;
   logic [SW-1:0]       need_sum;
   logic                fits;
   logic [SW-1:0]       rlen_w;
   logic [FW-1:0]       rcount;
   logic [SLOT_BITS-1:0] seq_idx;
   logic [SLOT_BITS-1:0] base_idx;
   rsp_item_type        simple_rsp;

   assign n_eff    = (win_ff < 8'(MAX_WINDOW)) ? win_ff : 8'(MAX_WINDOW);
   assign n_csr    = (csr_wdata < 8'(MAX_WINDOW)) ? csr_wdata : 8'(MAX_WINDOW);
   assign base_eff = item_ff.syn_flag ? item_ff.seq : base_ff;
   assign off      = item_ff.seq - base_eff + {8'd0, n_eff};
   assign seq_idx  = item_ff.seq[SLOT_BITS-1:0];
   assign base_idx = base_ff[SLOT_BITS-1:0];

   always_comb begin
      if (item_ff.cmd == CMD_READ) begin
         cls = CLS_READ;
      end else if (!item_ff.has_seq) begin
         cls = CLS_NO_SEQ;
      end else if (item_ff.rst_flag) begin
         cls = CLS_RESET;
      end else if ({1'b0, off} >= {8'd0, n_eff, 1'b0}) begin
         cls = CLS_OUTSIDE;
      end else if (off < {8'd0, n_eff}) begin
         cls = CLS_BEHIND;
      end else begin
         cls = CLS_INSERT;
      end
   end

   assign hit      = slot_valid_ff[seq_idx] && (rdata_ff.seq == item_ff.seq);
   assign need_sum = SW'(3 * rdata_ff.quads) + SW'(3) + SW'(fill_ff);
   assign fits     = (rdata_ff.quads == 8'd0) || (need_sum <= SW'(BUF_BYTES));

   assign rlen_w = SW'(item_ff.read_len);
   assign rcount = (rlen_w < SW'(fill_ff)) ? FW'(item_ff.read_len) : fill_ff;

   assign dp_status.cls      = cls;
   assign dp_status.out_free = !rsp_valid_ff || rsp_ready;
   assign dp_status.walk_ok  = slot_valid_ff[base_idx] && (rdata_ff.seq == base_ff) &&
                               (count_ff != 8'd255) && fits;

   // result of a transaction that needs no store access
   always_comb begin
      simple_rsp                 = '0;
      simple_rsp.window_adv      = adv_ff;
      simple_rsp.next_expected   = base_ff;
      simple_rsp.fill_level      = LEN_W'(fill_ff);
      simple_rsp.end_of_stream   = eof_ff;
      case (cls)
         CLS_READ: begin
            simple_rsp.status     = RS_READ_DONE;
            simple_rsp.read_count = LEN_W'(rcount);
            simple_rsp.fill_level = LEN_W'(fill_ff - rcount);
         end
         CLS_NO_SEQ: begin
            simple_rsp.status = RS_NO_SEQ;
         end
         CLS_RESET: begin
            simple_rsp.status        = RS_RESET;
            simple_rsp.end_of_stream = 1'b1;
         end
         CLS_BEHIND: begin
            simple_rsp.status        = RS_DUPLICATE;
            simple_rsp.ack_valid     = 1'b1;
            simple_rsp.ack_num       = item_ff.seq + 16'd1;
            simple_rsp.next_expected = base_eff;
            simple_rsp.end_of_stream = eof_ff && !item_ff.syn_flag;
         end
         default: begin
            simple_rsp.status        = RS_OUTSIDE;
            simple_rsp.next_expected = base_eff;
            simple_rsp.end_of_stream = eof_ff && !item_ff.syn_flag;
         end
      endcase
   end

   // reorder store: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (dp_cmd.op == OP_INSERT && !hit) begin
         store_mem[seq_idx] <= '{seq: item_ff.seq, quads: item_ff.payload_quads,
                                 pad: item_ff.pad_count};
      end
      if (dp_cmd.op == OP_LOOKUP) begin
         rdata_ff <= store_mem[seq_idx];
      end else if (dp_cmd.op == OP_WREAD) begin
         rdata_ff <= store_mem[base_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == OP_LOAD) begin
         item_ff <= req_item;
      end
      if (dp_cmd.op == OP_INSERT) begin
         dup_ff <= hit;
      end
      if (dp_cmd.op == OP_SIMPLE) begin
         rsp_ff <= simple_rsp;
      end else if (dp_cmd.op == OP_FINISH) begin
         rsp_ff.status          <= dup_ff ? RS_DUPLICATE : RS_ACCEPTED;
         rsp_ff.ack_valid       <= 1'b1;
         rsp_ff.ack_num         <= item_ff.seq + 16'd1;
         rsp_ff.window_adv      <= adv_ff;
         rsp_ff.delivered_count <= count_ff;
         rsp_ff.next_expected   <= base_ff;
         rsp_ff.fill_level      <= LEN_W'(fill_ff);
         rsp_ff.read_count      <= '0;
         rsp_ff.end_of_stream   <= eof_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff        <= 8'd8;
         adv_ff        <= sat_adv((8'd8 < 8'(MAX_WINDOW)) ? 8'd8 : 8'(MAX_WINDOW), 9'd0);
         held_ff       <= '0;
         base_ff       <= '0;
         fill_ff       <= '0;
         eof_ff        <= 1'b0;
         count_ff      <= '0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            win_ff <= csr_wdata;
            adv_ff <= sat_adv(n_csr, held_ff);
         end
         if (dp_cmd.op == OP_SIMPLE || dp_cmd.op == OP_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (dp_cmd.op)
            OP_SIMPLE: begin
               case (cls)
                  CLS_READ: begin
                     fill_ff <= fill_ff - rcount;
                  end
                  CLS_RESET: begin
                     eof_ff <= 1'b1;
                  end
                  CLS_BEHIND, CLS_OUTSIDE: begin
                     if (item_ff.syn_flag) begin
                        base_ff <= item_ff.seq;
                        eof_ff  <= 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            OP_LOOKUP: begin
               if (item_ff.syn_flag) begin
                  base_ff <= item_ff.seq;
                  eof_ff  <= 1'b0;
               end
            end
            OP_INSERT: begin
               count_ff <= '0;
               if (!hit) begin
                  slot_valid_ff[seq_idx] <= 1'b1;
                  if (!slot_valid_ff[seq_idx]) begin
                     held_ff <= held_ff + 9'd1;
                  end
               end
            end
            OP_WSTEP: begin
               if (rdata_ff.quads != 8'd0) begin
                  fill_ff <= fill_ff + FW'(3 * rdata_ff.quads) - FW'(rdata_ff.pad);
               end
               slot_valid_ff[base_idx] <= 1'b0;
               if (held_ff != 9'd0) begin
                  held_ff <= held_ff - 9'd1;
               end
               base_ff  <= base_ff + 16'd1;
               count_ff <= count_ff + 8'd1;
            end
            OP_FINISH: begin
               adv_ff <= sat_adv(n_eff, held_ff);
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[sv/selective_repeat_receiver_top.sv]
// Ordering: a read, drop, reset or out-of-window or old segment is registered, then its
// result is registered once the output is free; a stored segment goes through lookup,
// insert and the delivery walk first. Throughput: one transaction at a time; the walk
// reads the single-port store and checks each segment in turn before stepping on.
// Reset: synchronous, active high; clears base, fill, held count and valid bits;
// the reorder store itself keeps its contents and is guarded by the valid bits.
module selective_repeat_receiver_top
   import srr_pkg::*;
#(
   parameter int unsigned MAX_WINDOW = 255,
   parameter int unsigned BUF_BYTES  = 8192
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   srr_req_if.sink    req_chan,
   srr_rsp_if.source  rsp_chan
);

   req_item_type  req_item;
   rsp_item_type  rsp_item;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // gather the request fields into one item
   assign req_item.cmd           = req_chan.cmd;
   assign req_item.seq           = req_chan.seq;
   assign req_item.has_seq       = req_chan.has_seq;
   assign req_item.syn_flag      = req_chan.syn_flag;
   assign req_item.rst_flag      = req_chan.rst_flag;
   assign req_item.payload_quads = req_chan.payload_quads;
   assign req_item.pad_count     = req_chan.pad_count;
   assign req_item.read_len      = req_chan.read_len;

   // sequence each transaction: classify, look up, insert, walk, finish
   srr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // hold protocol state, the reorder store and the result register
   srr_dp #(
      .MAX_WINDOW (MAX_WINDOW),
      .BUF_BYTES  (BUF_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_item  (rsp_item),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // spread the result item onto the channel
   assign rsp_chan.status          = rsp_item.status;
   assign rsp_chan.ack_valid       = rsp_item.ack_valid;
   assign rsp_chan.ack_num         = rsp_item.ack_num;
   assign rsp_chan.window_adv      = rsp_item.window_adv;
   assign rsp_chan.delivered_count = rsp_item.delivered_count;
   assign rsp_chan.next_expected   = rsp_item.next_expected;
   assign rsp_chan.fill_level      = rsp_item.fill_level;
   assign rsp_chan.read_count      = rsp_item.read_count;
   assign rsp_chan.end_of_stream   = rsp_item.end_of_stream;

endmodule

[sv/srr_checker.sv]
// Port-level checks on the receiver's result channel, bound to the top level.
module srr_checker
   import srr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  status,
   input logic        ack_valid,
   input logic [15:0] ack_num,
   input logic [7:0]  delivered_count,
   input logic [13:0] read_count
);

   // a stalled result holds its status and acknowledgement
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(ack_num))
      else $error("stalled result changed");

   // only accepted or duplicate segments are acknowledged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ack_valid == (status == RS_ACCEPTED || status == RS_DUPLICATE))
      else $error("ack does not match status");

   // a result without acknowledgement carries a zero number
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !ack_valid |-> ack_num == 16'd0)
      else $error("ack number without ack");

   // bytes leave the buffer only on a read
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && read_count != 14'd0 |-> status == RS_READ_DONE)
      else $error("read count outside a read");

   // delivery happens only on accepted or duplicate stored segments
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && delivered_count != 8'd0 |-> ack_valid)
      else $error("delivery without ack");

endmodule

bind selective_repeat_receiver_top srr_checker u_srr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .status          (rsp_chan.status),
   .ack_valid       (rsp_chan.ack_valid),
   .ack_num         (rsp_chan.ack_num),
   .delivered_count (rsp_chan.delivered_count),
   .read_count      (rsp_chan.read_count)
);

[tb/sv/tb_selective_repeat_receiver_top.sv]
// Self-checking testbench of the selective-repeat receiver: random and directed segments.
module tb_selective_repeat_receiver_top
   import srr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BUF_LIMIT = 8192;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;

   srr_req_if req_chan ();
   srr_rsp_if rsp_chan ();

   selective_repeat_receiver_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source)
   );

   // Predictor state: a shadow of the receiver's window, store and buffer.
   entry_type    shadow_store [SLOTS];
   logic         shadow_valid [SLOTS];
   logic [15:0]  shadow_base;
   logic [7:0]   shadow_adv;
   int unsigned  shadow_held;
   int unsigned  shadow_fill;
   logic         shadow_eof;
   logic [7:0]   shadow_n;

   req_item_type segments_to_send [$];
   rsp_item_type expected_results [$];
   int unsigned  mismatch_count;
   int unsigned  sent_count;
   int unsigned  item_total;
   bit           quiet_phase;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic void refresh_window();
      shadow_adv = (shadow_n > shadow_held) ? 8'(shadow_n - shadow_held) : 8'd0;
   endfunction

   // Walk the in-order run from the base into the buffer while it fits.
   function automatic int unsigned deliver_in_order();
      int unsigned count;
      logic [7:0]  slot;
      entry_type   held;
      count = 0;
      while (count < 255) begin
         slot = shadow_base[7:0];
         if (!shadow_valid[slot]) break;
         held = shadow_store[slot];
         if (held.seq != shadow_base) break;
         if (held.quads != 0) begin
            if (3 * held.quads + 3 + shadow_fill > BUF_LIMIT) break;
            shadow_fill += 3 * held.quads - held.pad;
         end
         shadow_valid[slot] = 1'b0;
         if (shadow_held > 0) shadow_held--;
         shadow_base++;
         count++;
      end
      return count;
   endfunction

   function automatic rsp_item_type predict_receipt(req_item_type seg);
      rsp_item_type res;
      logic [15:0]  offset;
      logic [7:0]   slot;
      res = '0;
      res.window_adv = shadow_adv;
      if (seg.cmd == CMD_READ) begin
         res.read_count = (seg.read_len < shadow_fill) ? seg.read_len : LEN_W'(shadow_fill);
         shadow_fill -= res.read_count;
         res.status = RS_READ_DONE;
      end else if (!seg.has_seq) begin
         res.status = RS_NO_SEQ;
      end else if (seg.rst_flag) begin
         shadow_eof = 1'b1;
         res.status = RS_RESET;
      end else begin
         if (seg.syn_flag) begin
            shadow_base = seg.seq;
            shadow_eof  = 1'b0;
         end
         offset = seg.seq - shadow_base + 16'(shadow_n);
         if (32'(offset) >= 2 * 32'(shadow_n)) begin
            res.status = RS_OUTSIDE;
         end else begin
            res.ack_valid = 1'b1;
            res.ack_num   = seg.seq + 16'd1;
            if (32'(offset) < 32'(shadow_n)) begin
               res.status = RS_DUPLICATE;
            end else begin
               slot = seg.seq[7:0];
               if (shadow_valid[slot] && shadow_store[slot].seq == seg.seq) begin
                  res.status = RS_DUPLICATE;
               end else begin
                  if (!shadow_valid[slot]) shadow_held++;
                  shadow_valid[slot] = 1'b1;
                  shadow_store[slot] = '{seq: seg.seq, quads: seg.payload_quads,
                                         pad: seg.pad_count};
                  res.status = RS_ACCEPTED;
               end
               res.delivered_count = 8'(deliver_in_order());
               refresh_window();
            end
         end
      end
      res.next_expected = shadow_base;
      res.fill_level    = LEN_W'(shadow_fill);
      res.end_of_stream = shadow_eof;
      return res;
   endfunction

   function automatic req_item_type make_segment(logic [15:0] seq, bit syn, logic [7:0] quads,
                                                 logic [1:0] pad);
      req_item_type seg;
      seg = '0;
      seg.cmd           = CMD_SEGMENT;
      seg.seq           = seq;
      seg.has_seq       = 1'b1;
      seg.syn_flag      = syn;
      seg.payload_quads = quads;
      seg.pad_count     = pad;
      seg.read_len      = 14'($urandom);
      return seg;
   endfunction

   function automatic req_item_type make_read(int unsigned len);
      req_item_type seg;
      seg = '0;
      seg.cmd      = CMD_READ;
      seg.seq      = 16'($urandom);
      seg.has_seq  = 1'($urandom);
      seg.read_len = 14'(len);
      return seg;
   endfunction

   // Driver: hold the current transaction until accepted, then advance.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) sent_count <= sent_count + 1;
         if (segments_to_send.size() > 0 && (quiet_phase || $urandom_range(99) >= 15)) begin
            req_item_type seg;
            seg = segments_to_send.pop_front();
            expected_results.push_back(predict_receipt(seg));
            req_chan.valid         <= 1'b1;
            req_chan.cmd           <= seg.cmd;
            req_chan.seq           <= seg.seq;
            req_chan.has_seq       <= seg.has_seq;
            req_chan.syn_flag      <= seg.syn_flag;
            req_chan.rst_flag      <= seg.rst_flag;
            req_chan.payload_quads <= seg.payload_quads;
            req_chan.pad_count     <= seg.pad_count;
            req_chan.read_len      <= seg.read_len;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_item_type got;
            rsp_item_type want;
            got = '{rsp_chan.status, rsp_chan.ack_valid, rsp_chan.ack_num,
                    rsp_chan.window_adv, rsp_chan.delivered_count, rsp_chan.next_expected,
                    rsp_chan.fill_level, rsp_chan.read_count, rsp_chan.end_of_stream};
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected result %p", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Result differs: expected %p, actual %p", want, got);
               end
            end
         end
         rsp_chan.ready <= quiet_phase || ($urandom_range(99) >= 15);
      end
   end

   // Let the queue drain fully, then give the block time to go idle.
   task automatic drain_all();
      wait (segments_to_send.size() == 0 && sent_count == item_total);
      wait (expected_results.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_window(logic [7:0] n);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= n;
      shadow_n = n;
      refresh_window();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_item(req_item_type seg);
      segments_to_send.push_back(seg);
      item_total++;
   endtask

   // Mostly a sliding window of segments near the base, shuffled, with noise and reads.
   task automatic queue_random_burst(int unsigned count);
      logic [15:0] seq;
      req_item_type seg;
      repeat (count) begin
         case ($urandom_range(19))
            0: begin
               seg = make_segment(16'($urandom), 1'($urandom), 8'($urandom), 2'($urandom));
               seg.has_seq  = 1'($urandom);
               seg.rst_flag = 1'($urandom);
            end
            1, 2, 3: seg = make_read($urandom_range(3) == 0 ? $urandom_range(16383)
                                                              : $urandom_range(600));
            4: seg = make_segment(16'($urandom), 1'b0, 8'($urandom), 2'($urandom_range(2)));
            5: seg = make_segment(shadow_base + 16'($urandom_range(20)), 1'b1,
                                  8'($urandom_range(40)), 2'($urandom_range(2)));
            default: begin
               seq = shadow_base + 16'($urandom_range(2 * shadow_n + 1)) - 16'(shadow_n);
               seg = make_segment(seq, 1'b0,
                                  $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(30)),
                                  2'($urandom_range(2)));
            end
         endcase
         queue_item(seg);
         // Follow the predicted base loosely: wait for this item before choosing the next.
         wait (segments_to_send.size() == 0);
      end
   endtask

   initial begin
      logic [7:0] sizes [5];
      req_item_type seg;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      quiet_phase = 1'b0;
      mismatch_count = 0;
      sent_count  = 0;
      item_total  = 0;
      req_chan.valid = 1'b0;
      req_chan.cmd = 1'b0;
      req_chan.seq = '0;
      req_chan.has_seq = 1'b0;
      req_chan.syn_flag = 1'b0;
      req_chan.rst_flag = 1'b0;
      req_chan.payload_quads = '0;
      req_chan.pad_count = '0;
      req_chan.read_len = '0;
      rsp_chan.ready = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_store[i] = '0;
      end
      shadow_base = '0;
      shadow_held = 0;
      shadow_fill = 0;
      shadow_eof  = 1'b0;
      shadow_n    = 8'd8;
      refresh_window();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: drops, reset, SYN, out of order, duplicates, behind base, stale slot.
      seg = make_segment(16'd5, 1'b0, 8'd1, 2'd0);
      seg.has_seq = 1'b0;
      queue_item(seg);
      queue_item(make_segment(16'd2, 1'b0, 8'd255, 2'd2));
      queue_item(make_segment(16'd1, 1'b0, 8'd0, 2'd0));
      queue_item(make_segment(16'd2, 1'b0, 8'd3, 2'd1));
      queue_item(make_segment(16'd0, 1'b0, 8'd255, 2'd1));
      queue_item(make_segment(16'd0, 1'b0, 8'd4, 2'd0));
      queue_item(make_segment(16'd100, 1'b0, 8'd1, 2'd0));
      queue_item(make_segment(16'hFFFF, 1'b1, 8'd255, 2'd2));
      queue_item(make_segment(16'h0107, 1'b0, 8'd2, 2'd0));
      queue_item(make_segment(16'h0007, 1'b1, 8'd1, 2'd0));
      seg = make_segment(16'd9, 1'b0, 8'd0, 2'd0);
      seg.rst_flag = 1'b1;
      queue_item(seg);
      queue_item(make_read(14'h3FFF));
      queue_item(make_read(0));
      for (int i = 0; i < 12; i++) queue_item(make_segment(16'(20 + i), i == 0, 8'd255, 2'd2));
      drain_all();

      // Phases over window settings, extremes included; fill the buffer near its top.
      sizes = '{8'd1, 8'd255, 8'd0, 8'd32, 8'd4};
      foreach (sizes[k]) begin
         write_window(sizes[k]);
         quiet_phase = (k == 1);
         queue_random_burst(300);
         if (k == 1)
            for (int i = 0; i < 20; i++)
               queue_item(make_segment(shadow_base + 16'(i), 1'b0, 8'd255, 2'($urandom_range(2))));
         drain_all();
      end
      quiet_phase = 1'b0;
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #100ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
